>>> sv/lpcm_pkg.sv
// widths, payload structs and constants for the line pair closest midpoint block
package lpcm_pkg;

  localparam int COORD_W  = 24;
  localparam int DIR_W    = 16;
  localparam int N_W      = 2 * DIR_W + 1;
  localparam int Q_W      = DIR_W + N_W + 1;
  localparam int DP_W     = COORD_W + 1;
  localparam int SPLIT_Q  = 25;
  localparam int PLO_W    = SPLIT_Q + 1 + DP_W;
  localparam int PHI_W    = Q_W - SPLIT_Q + DP_W;
  localparam int NUM_W    = Q_W + DP_W + 2;
  localparam int NLO_W    = 39;
  localparam int MLO_W    = NLO_W + 1 + DIR_W;
  localparam int MHI_W    = NUM_W - NLO_W + DIR_W;
  localparam int P_W      = NUM_W + DIR_W;
  localparam int MAG_W    = P_W - 1;
  localparam int DEN_W    = 64;
  localparam int SUM_W    = MAG_W + 3;
  localparam int LATENCY  = MAG_W + 10;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_start_z;
    logic signed [DIR_W-1:0]   first_dir_x;
    logic signed [DIR_W-1:0]   first_dir_y;
    logic signed [DIR_W-1:0]   first_dir_z;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_start_z;
    logic signed [DIR_W-1:0]   second_dir_x;
    logic signed [DIR_W-1:0]   second_dir_y;
    logic signed [DIR_W-1:0]   second_dir_z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] mid_z;
    logic                      parallel_flag;
  } result_t;

endpackage

>>> sv/line_pair_closest_midpoint.sv
// line pair closest midpoint: fully pipelined fixed-point closest approach of two lines
// path: stages 1 to 6, divider entry, divider stages, post stages a to c (the output register)
// throughput: one line pair per cycle; six restoring dividers, one quotient bit per stage
// the whole pipeline advances together; it holds only while a result is stalled at the output
// reset (synchronous, active high) clears all stage valid bits; payload registers are not reset
module line_pair_closest_midpoint
  import lpcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};
  localparam logic LINE_NEG [2] = '{1'b0, 1'b1};
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);

  logic en;
  assign en = !result_valid || !result_stall;
  assign item_stall = !en;

  // input unpack
  logic signed [DIR_W-1:0]   a1 [3];
  logic signed [DIR_W-1:0]   a2 [3];
  logic signed [COORD_W-1:0] b1 [3];
  logic signed [COORD_W-1:0] b2 [3];

  always_comb begin
    a1[0] = item.first_dir_x;    a1[1] = item.first_dir_y;    a1[2] = item.first_dir_z;
    a2[0] = item.second_dir_x;   a2[1] = item.second_dir_y;   a2[2] = item.second_dir_z;
    b1[0] = item.first_start_x;  b1[1] = item.first_start_y;  b1[2] = item.first_start_z;
    b2[0] = item.second_start_x; b2[1] = item.second_start_y; b2[2] = item.second_start_z;
  end

  // stage 1: normal, start difference and sum
  logic                    v1;
  logic signed [N_W-1:0]   n1  [3];
  logic signed [DP_W-1:0]  dp1 [3];
  logic signed [DP_W-1:0]  ps1 [3];
  logic signed [DIR_W-1:0] da1 [3];
  logic signed [DIR_W-1:0] db1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n1[k]  <= a1[NX[k]] * a2[NY[k]] - a1[NY[k]] * a2[NX[k]];
        dp1[k] <= DP_W'(b2[k]) - DP_W'(b1[k]);
        ps1[k] <= DP_W'(b1[k]) + DP_W'(b2[k]);
        da1[k] <= a1[k];
        db1[k] <= a2[k];
      end
    end
  end

  // stage 2: squares of the normal, direction cross normal
  logic                    v2;
  logic [DEN_W-1:0]        sq2 [3];
  logic signed [Q_W-1:0]   qa2 [3];
  logic signed [Q_W-1:0]   qb2 [3];
  logic signed [DP_W-1:0]  dp2 [3];
  logic signed [DP_W-1:0]  ps2 [3];
  logic signed [DIR_W-1:0] da2 [3];
  logic signed [DIR_W-1:0] db2 [3];
  logic signed [2*N_W-1:0] sqw [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqw[k] = n1[k] * n1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq2[k] <= sqw[k][DEN_W-1:0];
        qa2[k] <= da1[NX[k]] * n1[NY[k]] - da1[NY[k]] * n1[NX[k]];
        qb2[k] <= db1[NX[k]] * n1[NY[k]] - db1[NY[k]] * n1[NX[k]];
        dp2[k] <= dp1[k];
        ps2[k] <= ps1[k];
        da2[k] <= da1[k];
        db2[k] <= db1[k];
      end
    end
  end

  // stage 3: denominator, partial products of the numerators
  logic                    v3;
  logic [DEN_W-1:0]        den3;
  logic signed [PLO_W-1:0] pl3 [2][3];
  logic signed [PHI_W-1:0] ph3 [2][3];
  logic signed [DP_W-1:0]  ps3 [3];
  logic signed [DIR_W-1:0] da3 [3];
  logic signed [DIR_W-1:0] db3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= sq2[0] + sq2[1] + sq2[2];
      for (int k = 0; k < 3; k++) begin
        pl3[0][k] <= $signed({1'b0, qb2[k][SPLIT_Q-1:0]}) * dp2[k];
        ph3[0][k] <= $signed(qb2[k][Q_W-1:SPLIT_Q]) * dp2[k];
        pl3[1][k] <= $signed({1'b0, qa2[k][SPLIT_Q-1:0]}) * dp2[k];
        ph3[1][k] <= $signed(qa2[k][Q_W-1:SPLIT_Q]) * dp2[k];
        ps3[k] <= ps2[k];
        da3[k] <= da2[k];
        db3[k] <= db2[k];
      end
    end
  end

  // stage 4: numerators
  logic                    v4;
  logic                    flag4;
  logic [DEN_W-1:0]        den4;
  logic signed [NUM_W-1:0] num4 [2];
  logic signed [DP_W-1:0]  ps4 [3];
  logic signed [DIR_W-1:0] da4 [3];
  logic signed [DIR_W-1:0] db4 [3];
  logic signed [NUM_W-1:0] num_c [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      num_c[l] = '0;
      for (int k = 0; k < 3; k++) begin
        num_c[l] = num_c[l] + (NUM_W'(ph3[l][k]) <<< SPLIT_Q) + NUM_W'(pl3[l][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag4   <= (den3 == '0);
      den4    <= den3;
      num4[0] <= num_c[0];
      num4[1] <= -num_c[1];
      for (int k = 0; k < 3; k++) begin
        ps4[k] <= ps3[k];
        da4[k] <= da3[k];
        db4[k] <= db3[k];
      end
    end
  end

  // stage 5: numerator times direction component, split products
  logic                    v5;
  logic                    flag5;
  logic [DEN_W-1:0]        den5;
  logic signed [MLO_W-1:0] ml5 [2][3];
  logic signed [MHI_W-1:0] mh5 [2][3];
  logic signed [DP_W-1:0]  ps5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag5 <= flag4;
      den5  <= den4;
      for (int k = 0; k < 3; k++) begin
        ml5[0][k] <= $signed({1'b0, num4[0][NLO_W-1:0]}) * da4[k];
        mh5[0][k] <= $signed(num4[0][NUM_W-1:NLO_W]) * da4[k];
        ml5[1][k] <= $signed({1'b0, num4[1][NLO_W-1:0]}) * db4[k];
        mh5[1][k] <= $signed(num4[1][NUM_W-1:NLO_W]) * db4[k];
        ps5[k] <= ps4[k];
      end
    end
  end

  // stage 6: full dividend products
  logic                    v6;
  logic                    flag6;
  logic [DEN_W-1:0]        den6;
  logic signed [P_W-1:0]   p6 [2][3];
  logic signed [DP_W-1:0]  ps6 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag6 <= flag5;
      den6  <= den5;
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          p6[l][k] <= (P_W'(mh5[l][k]) <<< NLO_W) + P_W'(ml5[l][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        ps6[k] <= ps5[k];
      end
    end
  end

  // divider pipeline, entry stage takes sign and magnitude
  logic                    dvld  [MAG_W+1];
  logic                    dflag [MAG_W+1];
  logic [DEN_W-1:0]        dden  [MAG_W+1];
  logic [DEN_W-1:0]        drem  [MAG_W+1][2][3];
  logic [MAG_W-1:0]        dacc  [MAG_W+1][2][3];
  logic                    dneg  [MAG_W+1][2][3];
  logic signed [DP_W-1:0]  dps   [MAG_W+1][3];
  logic signed [P_W-1:0]   pabs  [2][3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        pabs[l][k] = p6[l][k][P_W-1] ? -p6[l][k] : p6[l][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dflag[0] <= flag6;
      dden[0]  <= den6;
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          drem[0][l][k] <= '0;
          dacc[0][l][k] <= pabs[l][k][MAG_W-1:0];
          dneg[0][l][k] <= p6[l][k][P_W-1] ^ LINE_NEG[l];
        end
      end
      for (int k = 0; k < 3; k++) begin
        dps[0][k] <= ps6[k];
      end
    end
  end

  for (genvar j = 0; j < MAG_W; j++) begin : g_div
    logic [DEN_W:0] sh   [2][3];
    logic [DEN_W:0] diff [2][3];
    logic           qbit [2][3];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          sh[l][k]   = {drem[j][l][k], dacc[j][l][k][MAG_W-1]};
          diff[l][k] = sh[l][k] - {1'b0, dden[j]};
          qbit[l][k] = !diff[l][k][DEN_W];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[j+1] <= 1'b0;
      end else if (en) begin
        dvld[j+1] <= dvld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dflag[j+1] <= dflag[j];
        dden[j+1]  <= dden[j];
        for (int l = 0; l < 2; l++) begin
          for (int k = 0; k < 3; k++) begin
            drem[j+1][l][k] <= qbit[l][k] ? diff[l][k][DEN_W-1:0] : sh[l][k][DEN_W-1:0];
            dacc[j+1][l][k] <= {dacc[j][l][k][MAG_W-2:0], qbit[l][k]};
            dneg[j+1][l][k] <= dneg[j][l][k];
          end
        end
        for (int k = 0; k < 3; k++) begin
          dps[j+1][k] <= dps[j][k];
        end
      end
    end
  end

  // post stage a: signed offsets
  logic                    va;
  logic                    flaga;
  logic signed [SUM_W-1:0] oa  [2][3];
  logic signed [DP_W-1:0]  psa [3];
  logic signed [SUM_W-1:0] qmag [2][3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        qmag[l][k] = $signed(SUM_W'(dacc[MAG_W][l][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= dvld[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flaga <= dflag[MAG_W];
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          oa[l][k] <= dneg[MAG_W][l][k] ? -qmag[l][k] : qmag[l][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        psa[k] <= dps[MAG_W][k];
      end
    end
  end

  // post stage b: sum of both closest points
  logic                    vb;
  logic                    flagb;
  logic signed [SUM_W-1:0] sb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flagb <= flaga;
      for (int k = 0; k < 3; k++) begin
        sb[k] <= SUM_W'(psa[k]) + oa[0][k] + oa[1][k];
      end
    end
  end

  // post stage c: floor half, saturate, zero for a parallel pair, output register
  logic signed [SUM_W-1:0]   hc  [3];
  logic signed [COORD_W-1:0] mid [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hc[k] = sb[k] >>> 1;
      if (flagb) begin
        mid[k] = '0;
      end else if (hc[k] > C_MAX) begin
        mid[k] = C_MAX[COORD_W-1:0];
      end else if (hc[k] < C_MIN) begin
        mid[k] = C_MIN[COORD_W-1:0];
      end else begin
        mid[k] = hc[k][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.mid_x         <= mid[0];
      result.mid_y         <= mid[1];
      result.mid_z         <= mid[2];
      result.parallel_flag <= flagb;
    end
  end

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.parallel_flag |->
      result.mid_x == '0 && result.mid_y == '0 && result.mid_z == '0)
    else $error("parallel result with nonzero midpoint");

  a_tail_advance: assert property (@(posedge clk) disable iff (rst)
    en && vb |=> result_valid)
    else $error("result lost between last stage and output register");

  a_div_advance: assert property (@(posedge clk) disable iff (rst)
    en && dvld[MAG_W] |=> va)
    else $error("transfer lost leaving the divider pipeline");

endmodule
